/* design/atlas_rectangle_packer_top_defines.svh */
// assertion macros for the atlas rectangle packer
`ifndef ATLAS_RECTANGLE_PACKER_TOP_DEFINES_SVH
`define ATLAS_RECTANGLE_PACKER_TOP_DEFINES_SVH

// a implies b in the same cycle
`define ARP_ASSERT_NOW(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// a implies b in the next cycle
`define ARP_ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

`endif

/* design/arp_pkg.sv */
package arp_pkg;

  localparam int FIELD_BITS = 16;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_FIT   = 2'd1;
  localparam logic [1:0] STATUS_NODES    = 2'd2;
  localparam logic [1:0] STATUS_STACK    = 2'd3;

  localparam logic FUNC_CLEAR = 1'b0;
  localparam logic FUNC_PLACE = 1'b1;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  localparam logic [FIELD_BITS-1:0] RESET_ATLAS_WIDTH  = 16'd1024;
  localparam logic [FIELD_BITS-1:0] RESET_ATLAS_HEIGHT = 16'd1024;

  typedef struct packed {
    logic                  func;
    logic [FIELD_BITS-1:0] req_width;
    logic [FIELD_BITS-1:0] req_height;
  } in_item_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [FIELD_BITS-1:0] pos_x;
    logic [FIELD_BITS-1:0] pos_y;
  } out_item_t;

endpackage

/* design/atlas_rectangle_packer_top.sv */
// Guillotine-tree rectangle packer. A clear item rebuilds the tree as one free root of
// atlas_width x atlas_height (register writes act at the next clear), then gives its result.
// A place item walks the node memory depth first: it checks the root, descends internal
// nodes, splits leaves into two children and backtracks from the pending stack, then gives
// its result, so the time grows with tree depth and with backtracking.
// The walk is set by the node memory, which has two registered read ports and one write port.
// After reset the S_INIT state writes the root before the first item is taken.
`include "atlas_rectangle_packer_top_defines.svh"

module atlas_rectangle_packer_top import arp_pkg::*; #(
  parameter int MAX_NODES   = 1024,
  parameter int STACK_DEPTH = 32,
  parameter int COORD_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [FIELD_BITS-1:0] cfg_data
);

  localparam int NB = $clog2(MAX_NODES);
  localparam int CB = COORD_BITS;
  localparam int SB = $clog2(STACK_DEPTH);
  localparam int LB = $clog2(STACK_DEPTH + 1);
  localparam int CNTB = NB + 1;
  localparam logic [CNTB-1:0] COUNT_LIMIT = CNTB'(MAX_NODES - 2);
  localparam logic [LB-1:0] STACK_FULL = LB'(STACK_DEPTH);

  typedef struct packed {
    logic          full;
    logic [NB-1:0] link;
    logic [CB-1:0] h;
    logic [CB-1:0] w;
    logic [CB-1:0] y;
    logic [CB-1:0] x;
  } node_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_ROOT, S_VISIT, S_CHILD, S_SPL_A, S_SPL_B, S_POP, S_LOAD, S_RESP
  } state_t;

  state_t          state;
  node_t           node_mem [MAX_NODES];
  logic [NB-1:0]   stack_mem [STACK_DEPTH];
  node_t           rd_a, rd_b;
  logic [NB-1:0]   stk_q;
  logic [NB-1:0]   rd_a_addr, rd_b_addr;
  logic [NB-1:0]   rd_a_addr_q, rd_b_addr_q;
  logic            we;
  logic [NB-1:0]   wr_addr;
  node_t           wr_data;
  logic            stk_we;

  logic [FIELD_BITS-1:0] atlas_width, atlas_height;
  logic [CNTB-1:0] node_count;
  logic [LB-1:0]   stack_level;
  node_t           cur;
  logic [NB-1:0]   ix;
  logic [NB-1:0]   c_ix;
  node_t           child0, child1;
  logic [CB-1:0]   req_w, req_h;
  out_item_t       res;

  node_t           root;
  logic            accept, is_leaf, exact, no_room, ok0, ok1, root_ok;
  logic [CB-1:0]   dw, dh;
  node_t           new0, new1;
  logic [NB-1:0]   link1;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  always_comb begin
    root = '0;
    root.w = CB'(atlas_width);
    root.h = CB'(atlas_height);
  end

  assign is_leaf = (cur.link == '0);
  assign dw      = cur.w - req_w;
  assign dh      = cur.h - req_h;
  assign exact   = (dw == '0) && (dh == '0);
  assign no_room = (node_count > COUNT_LIMIT);
  assign link1   = cur.link + NB'(1);
  assign ok0     = !rd_a.full && (rd_a.w >= req_w) && (rd_a.h >= req_h);
  assign ok1     = !rd_b.full && (rd_b.w >= req_w) && (rd_b.h >= req_h);
  assign root_ok = !rd_a.full && (rd_a.w >= req_w) && (rd_a.h >= req_h);

  always_comb begin
    new0 = '0;
    new1 = '0;
    new0.x = cur.x;
    new0.y = cur.y;
    if (dw > dh) begin
      new0.w = req_w;
      new0.h = cur.h;
      new1.x = cur.x + req_w;
      new1.y = cur.y;
      new1.w = dw;
      new1.h = cur.h;
    end else begin
      new0.w = cur.w;
      new0.h = req_h;
      new1.x = cur.x;
      new1.y = cur.y + req_h;
      new1.w = cur.w;
      new1.h = dh;
    end
  end

  always_comb begin
    rd_a_addr = '0;
    rd_b_addr = '0;
    case (state)
      S_VISIT: begin
        rd_a_addr = cur.link;
        rd_b_addr = link1;
      end
      S_POP:   rd_a_addr = stk_q;
      default: rd_a_addr = '0;
    endcase
  end

  always_comb begin
    we      = 1'b0;
    wr_addr = '0;
    wr_data = root;
    case (state)
      S_INIT: we = 1'b1;
      S_IDLE: we = accept && (in_item.func == FUNC_CLEAR);
      S_VISIT: begin
        wr_addr = ix;
        wr_data = cur;
        if (is_leaf && exact) begin
          we = 1'b1;
          wr_data.full = 1'b1;
        end else if (is_leaf && !no_room) begin
          we = 1'b1;
          wr_data.link = node_count[NB-1:0];
        end
      end
      S_SPL_A: begin
        we      = 1'b1;
        wr_addr = c_ix;
        wr_data = child0;
      end
      S_SPL_B: begin
        we      = 1'b1;
        wr_addr = c_ix + NB'(1);
        wr_data = child1;
      end
      default: we = 1'b0;
    endcase
  end

  assign stk_we = (state == S_CHILD) && ok0 && ok1 && (stack_level < STACK_FULL);

  always_ff @(posedge clk) begin
    if (we) begin
      node_mem[wr_addr] <= wr_data;
    end
    rd_a <= node_mem[rd_a_addr];
    rd_b <= node_mem[rd_b_addr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_mem[stack_level[SB-1:0]] <= rd_b_addr_q;
    end
    stk_q <= stack_mem[SB'(stack_level - LB'(1))];
  end

  always_ff @(posedge clk) begin
    rd_b_addr_q <= rd_b_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_INIT;
      out_valid    <= 1'b0;
      node_count   <= CNTB'(1);
      stack_level  <= '0;
      atlas_width  <= RESET_ATLAS_WIDTH;
      atlas_height <= RESET_ATLAS_HEIGHT;
    end else begin
      if (out_valid && out_ready && (state != S_RESP)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_INIT: state <= S_IDLE;
        S_IDLE: begin
          if (cfg_valid) begin
            if (cfg_index == CFG_WIDTH) begin
              atlas_width <= cfg_data;
            end else begin
              atlas_height <= cfg_data;
            end
          end
          if (accept) begin
            res         <= '0;
            req_w       <= CB'(in_item.req_width);
            req_h       <= CB'(in_item.req_height);
            stack_level <= '0;
            if (in_item.func == FUNC_CLEAR) begin
              node_count <= CNTB'(1);
              state      <= S_RESP;
            end else begin
              state <= S_ROOT;
            end
          end
        end
        S_ROOT: begin
          if (root_ok) begin
            cur   <= rd_a;
            ix    <= '0;
            state <= S_VISIT;
          end else begin
            res.status <= STATUS_NO_FIT;
            state      <= S_RESP;
          end
        end
        S_VISIT: begin
          if (!is_leaf) begin
            state <= S_CHILD;
          end else if (exact) begin
            res.pos_x <= FIELD_BITS'(cur.x);
            res.pos_y <= FIELD_BITS'(cur.y);
            state     <= S_RESP;
          end else if (no_room) begin
            res.status <= STATUS_NODES;
            state      <= S_RESP;
          end else begin
            c_ix       <= node_count[NB-1:0];
            child0     <= new0;
            child1     <= new1;
            node_count <= node_count + CNTB'(2);
            state      <= S_SPL_A;
          end
        end
        S_CHILD: begin
          if (ok0) begin
            if (ok1 && (stack_level >= STACK_FULL)) begin
              res.status <= STATUS_STACK;
              state      <= S_RESP;
            end else begin
              if (ok1) begin
                stack_level <= stack_level + LB'(1);
              end
              cur   <= rd_a;
              ix    <= rd_a_addr_q;
              state <= S_VISIT;
            end
          end else if (ok1) begin
            cur   <= rd_b;
            ix    <= rd_b_addr_q;
            state <= S_VISIT;
          end else if (stack_level != '0) begin
            stack_level <= stack_level - LB'(1);
            state       <= S_POP;
          end else begin
            res.status <= STATUS_NO_FIT;
            state      <= S_RESP;
          end
        end
        S_SPL_A: state <= S_SPL_B;
        S_SPL_B: begin
          cur   <= child0;
          ix    <= c_ix;
          state <= S_VISIT;
        end
        S_POP: begin
          ix    <= stk_q;
          state <= S_LOAD;
        end
        S_LOAD: begin
          cur   <= rd_a;
          state <= S_VISIT;
        end
        S_RESP: begin
          if (!out_valid || out_ready) begin
            out_item  <= res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_a_addr_q <= rd_a_addr;
  end

  `ARP_ASSERT_NEXT(a_busy_after_accept, accept, !in_ready)
  `ARP_ASSERT_NOW(a_count_bound, 1'b1, node_count <= CNTB'(MAX_NODES))
  `ARP_ASSERT_NOW(a_stack_bound, 1'b1, stack_level <= STACK_FULL)
  `ARP_ASSERT_NEXT(a_resp_holds, state == S_RESP && out_valid && !out_ready, state == S_RESP)

endmodule

/* verif/atlas_rectangle_packer_top_tb.sv */
`timescale 1ns / 1ps

module atlas_rectangle_packer_top_tb;
  import arp_pkg::*;

  localparam int NODE_LIMIT = 1024;
  localparam int PEND_DEPTH = 32;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_item = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic                  cfg_index = CFG_WIDTH;
  logic [FIELD_BITS-1:0] cfg_data = '0;

  atlas_rectangle_packer_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // shadow copy of the guillotine tree
  logic [15:0] node_x[NODE_LIMIT];
  logic [15:0] node_y[NODE_LIMIT];
  logic [15:0] node_w[NODE_LIMIT];
  logic [15:0] node_h[NODE_LIMIT];
  int unsigned node_first[NODE_LIMIT];
  bit          node_taken[NODE_LIMIT];
  int unsigned nodes_used;
  int unsigned pending[PEND_DEPTH];
  int unsigned pending_level;
  logic [15:0] atlas_w = RESET_ATLAS_WIDTH;
  logic [15:0] atlas_h = RESET_ATLAS_HEIGHT;

  out_item_t placements_due[$];
  bit        lazy_in, lazy_out;
  int        fails, items_sent, results_seen;
  int        status_seen[4];
  int        stall_left;

  function automatic void rebuild_tree();
    node_x[0] = '0;
    node_y[0] = '0;
    node_w[0] = atlas_w;
    node_h[0] = atlas_h;
    node_first[0] = 0;
    node_taken[0] = 1'b0;
    nodes_used = 1;
    pending_level = 0;
  endfunction

  function automatic bit room_for(int unsigned ix, logic [15:0] w, logic [15:0] h);
    if (ix >= NODE_LIMIT || node_taken[ix]) return 1'b0;
    return node_w[ix] >= w && node_h[ix] >= h;
  endfunction

  function automatic out_item_t place_rect(logic [15:0] w, logic [15:0] h);
    out_item_t   r;
    int unsigned ix, link, c;
    logic [15:0] dw, dh;
    bit          ok0, ok1;
    r = '0;
    r.status = STATUS_OK;
    pending_level = 0;
    ix = 0;
    if (!room_for(0, w, h)) begin
      r.status = STATUS_NO_FIT;
      return r;
    end
    while (1) begin
      link = node_first[ix];
      if (link != 0) begin
        ok0 = room_for(link, w, h);
        ok1 = room_for(link + 1, w, h);
        if (ok0) begin
          if (ok1) begin
            if (pending_level >= PEND_DEPTH) begin
              r.status = STATUS_STACK;
              return r;
            end
            pending[pending_level] = link + 1;
            pending_level++;
          end
          ix = link;
          continue;
        end
        if (ok1) begin
          ix = link + 1;
          continue;
        end
      end else begin
        dw = node_w[ix] - w;
        dh = node_h[ix] - h;
        if (dw == 0 && dh == 0) begin
          node_taken[ix] = 1'b1;
          r.pos_x = node_x[ix];
          r.pos_y = node_y[ix];
          return r;
        end
        if (nodes_used > NODE_LIMIT - 2) begin
          r.status = STATUS_NODES;
          return r;
        end
        c = nodes_used;
        nodes_used += 2;
        node_first[c] = 0;
        node_first[c+1] = 0;
        node_taken[c] = 1'b0;
        node_taken[c+1] = 1'b0;
        node_x[c] = node_x[ix];
        node_y[c] = node_y[ix];
        if (dw > dh) begin
          node_w[c] = w;
          node_h[c] = node_h[ix];
          node_x[c+1] = node_x[ix] + w;
          node_y[c+1] = node_y[ix];
          node_w[c+1] = dw;
          node_h[c+1] = node_h[ix];
        end else begin
          node_w[c] = node_w[ix];
          node_h[c] = h;
          node_x[c+1] = node_x[ix];
          node_y[c+1] = node_y[ix] + h;
          node_w[c+1] = node_w[ix];
          node_h[c+1] = dh;
        end
        node_first[ix] = c;
        ix = c;
        continue;
      end
      if (pending_level > 0) begin
        pending_level--;
        ix = pending[pending_level];
        if (ix >= NODE_LIMIT) ix = 0;
      end else begin
        r.status = STATUS_NO_FIT;
        return r;
      end
    end
  endfunction

  // one item on the input channel; valid stays up until the next call or a register write
  task automatic send_item(logic func, logic [15:0] w, logic [15:0] h);
    int        gap;
    out_item_t due;
    gap = lazy_in ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= '{func: func, req_width: w, req_height: h};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (func == FUNC_CLEAR) begin
      rebuild_tree();
      due = '0;
      due.status = STATUS_OK;
    end else begin
      due = place_rect(w, h);
    end
    placements_due.push_back(due);
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (placements_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_WIDTH) atlas_w = value;
    else atlas_h = value;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_atlas(logic [15:0] w, logic [15:0] h);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    send_item(FUNC_CLEAR, '0, '0);
  endtask

  // result checker and output stall generator
  always @(posedge clk) begin : result_check
    out_item_t exp_item;
    int        g;
    if (!rst) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (placements_due.size() == 0) begin
          $error("unexpected result status=%0d x=%0d y=%0d",
                 out_item.status, out_item.pos_x, out_item.pos_y);
          fails++;
        end else begin
          exp_item = placements_due.pop_front();
          status_seen[exp_item.status]++;
          if (out_item.status !== exp_item.status) begin
            $error("status expected %0d actual %0d", exp_item.status, out_item.status);
            fails++;
          end
          if (out_item.pos_x !== exp_item.pos_x) begin
            $error("pos_x expected %0d actual %0d", exp_item.pos_x, out_item.pos_x);
            fails++;
          end
          if (out_item.pos_y !== exp_item.pos_y) begin
            $error("pos_y expected %0d actual %0d", exp_item.pos_y, out_item.pos_y);
            fails++;
          end
        end
        g = lazy_out ? $urandom_range(0, 17) : 0;
        stall_left <= g;
        out_ready <= (g == 0);
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready <= (stall_left == 1);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic test_basic_cases();
    lazy_in = 1'b0;
    lazy_out = 1'b0;
    send_item(FUNC_PLACE, 16'd1024, 16'd1024);
    send_item(FUNC_PLACE, 16'd1, 16'd1);
    send_item(FUNC_CLEAR, 16'hffff, 16'hffff);
    send_item(FUNC_PLACE, 16'hffff, 16'hffff);
    send_item(FUNC_PLACE, 16'd0, 16'd0);
    send_item(FUNC_PLACE, 16'd1024, 16'd0);
    send_item(FUNC_PLACE, 16'd100, 16'd300);
    send_item(FUNC_PLACE, 16'd300, 16'd100);
    send_item(FUNC_PLACE, 16'd0, 16'd1024);
    send_item(FUNC_PLACE, 16'd1025, 16'd1);
    send_item(FUNC_PLACE, 16'd1, 16'd1025);
    send_item(FUNC_PLACE, 16'd924, 16'd724);
    lazy_in = 1'b1;
    lazy_out = 1'b1;
    send_item(FUNC_CLEAR, 16'd0, 16'd0);
    send_item(FUNC_PLACE, 16'd512, 16'd512);
    send_item(FUNC_PLACE, 16'd512, 16'd512);
  endtask

  task automatic test_atlas_extremes();
    set_atlas(16'hffff, 16'hffff);
    send_item(FUNC_PLACE, 16'hffff, 16'hffff);
    send_item(FUNC_PLACE, 16'd0, 16'd0);
    set_atlas(16'd1, 16'd1);
    send_item(FUNC_PLACE, 16'd1, 16'd1);
    send_item(FUNC_PLACE, 16'd1, 16'd1);
    set_atlas(16'd0, 16'd0);
    send_item(FUNC_PLACE, 16'd1, 16'd0);
    send_item(FUNC_PLACE, 16'd0, 16'd0);
    send_item(FUNC_PLACE, 16'd0, 16'd0);
  endtask

  // shrinking squares split leaves on both axes, so the node store runs out
  task automatic test_node_store_full();
    lazy_in = 1'b0;
    lazy_out = 1'b0;
    set_atlas(16'hffff, 16'hffff);
    for (int i = 0; i < 300; i++) send_item(FUNC_PLACE, 16'(1000 - i), 16'(1000 - i));
  endtask

  task automatic test_deep_walk();
    lazy_in = 1'b1;
    lazy_out = 1'b0;
    set_atlas(16'hffff, 16'hffff);
    for (int i = 0; i < 48; i++)
      send_item(FUNC_PLACE, 16'(40000 >> (i / 3)) + 16'(i), 16'(30000 >> (i / 3)));
    for (int i = 0; i < 12; i++) send_item(FUNC_PLACE, 16'd0, 16'd0);
  endtask

  task automatic test_random_traffic();
    logic [15:0] w, h, span_w, span_h;
    int          pick;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin w = 16'hffff; h = 16'hffff; end
        1: begin w = 16'($urandom_range(1, 2048)); h = 16'($urandom_range(1, 2048)); end
        2: begin w = 16'($urandom_range(1, 64)); h = 16'hffff; end
        default: begin w = 16'($urandom); h = 16'($urandom_range(1, 256)); end
      endcase
      lazy_in = phase[0];
      lazy_out = phase[1] | phase[2];
      set_atlas(w, h);
      span_w = (w >> 3) + 16'd1;
      span_h = (h >> 3) + 16'd1;
      for (int i = 0; i < 80; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 4)
          send_item(FUNC_CLEAR, 16'($urandom), 16'($urandom));
        else if (pick < 10)
          send_item(FUNC_PLACE, 16'($urandom), 16'($urandom));
        else if (pick < 14)
          send_item(FUNC_PLACE, 16'($urandom_range(0, 1)), 16'($urandom_range(0, 1)));
        else
          send_item(FUNC_PLACE, 16'($urandom_range(0, span_w)), 16'($urandom_range(0, span_h)));
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    rebuild_tree();
    @(posedge clk);
    test_basic_cases();
    test_atlas_extremes();
    test_node_store_full();
    test_deep_walk();
    test_random_traffic();
    drain_results();
    repeat (50) @(posedge clk);
    $display("sent %0d items, checked %0d results", items_sent, results_seen);
    $display("placed/cleared %0d, no fit %0d, node store full %0d, stack overflow %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (fails == 0 && placements_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #(200_000_000);
    $display("timeout with %0d results outstanding", placements_due.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/arp_pkg.sv
design/atlas_rectangle_packer_top.sv
verif/atlas_rectangle_packer_top_tb.sv
